// ===== design/aecl_pkg.sv =====
package aecl_pkg;

    // Column limit of one read; further columns are ignored
    localparam int unsigned MAX_COLUMNS = 65535;
    localparam logic [15:0] COL_LIMIT   = 16'(MAX_COLUMNS);

    // Column operation codes
    localparam logic [2:0] OP_M  = 3'd0;
    localparam logic [2:0] OP_I  = 3'd1;
    localparam logic [2:0] OP_D  = 3'd2;
    localparam logic [2:0] OP_S  = 3'd3;
    localparam logic [2:0] OP_EQ = 3'd4;
    localparam logic [2:0] OP_X  = 3'd5;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_JOIN_GAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN = 1'b1;

    localparam logic [15:0] JOIN_GAP_RST = 16'd5;
    localparam logic [15:0] MIN_SPAN_RST = 16'd2;

    // Queue geometry (depth a power of two, at least 2)
    localparam int unsigned QUE_DEPTH = 4;
    localparam int unsigned QUE_PTR_W = $clog2(QUE_DEPTH);
    localparam int unsigned QUE_CNT_W = $clog2(QUE_DEPTH + 1);

    localparam logic [31:0] POS_NONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  read_base;
        logic [7:0]  ref_base;
        logic [7:0]  qual;
        logic [31:0] start_pos;
        logic        first;
        logic        last_col;
    } col_item_t;

    typedef struct packed {
        logic [15:0] col_start;
        logic [15:0] col_end;
        logic [31:0] ref_min;
        logic [31:0] ref_max;
        logic [23:0] qual_sum;
        logic [15:0] span_len;
        logic [15:0] ref_bases;
        logic [15:0] read_bases;
        logic        last;
    } res_item_t;

    // Classified column handed from the front to the back
    typedef struct packed {
        logic        first;
        logic        last_col;
        logic        active;
        logic        event_hit;
        logic        refc;
        logic        readc;
        logic [7:0]  cq;
        logic [15:0] col;
        logic [31:0] pos;
    } col_rec_t;

    typedef struct packed {
        logic [15:0] join_gap;
        logic [15:0] min_span;
    } cfg_t;

endpackage

// ===== design/alignment_event_clusterer_unit.sv =====
// A column request is held in the front queue stage, then its results in the result queue
//   stage.
// Throughput: one column request per cycle while the queues have room; the back stalls only
//   while its result queue has fewer than two free slots.
// Reset (rst_n, asynchronous, active low): queues empty, no open cluster, column and
//   reference counters zero, join gap 5 and minimum span 2.
module alignment_event_clusterer_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               col_valid,
    output logic                               col_ready,
    input  aecl_pkg::col_item_t                col_item,
    output logic                               res_valid,
    input  logic                               res_ready,
    output aecl_pkg::res_item_t                res_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [aecl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                        cfg_data
);
    import aecl_pkg::*;

    // Configuration registers; the user must write them only while the block is idle (not enforced)
    cfg_t     cfg_reg, cfg_next;

    // Classified column request between the front and the back
    logic     q_valid;
    logic     q_ready;
    col_rec_t q_rec;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_JOIN_GAP: cfg_next.join_gap = cfg_data;
                CFG_MIN_SPAN: cfg_next.min_span = cfg_data;
                default:      cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.join_gap <= JOIN_GAP_RST;
            cfg_reg.min_span <= MIN_SPAN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: count columns, track the reference position, classify each column and hold it
    // in a short queue so the front keeps accepting while the back stalls, until it is full
    aecl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .col_valid (col_valid),
        .col_ready (col_ready),
        .col_item  (col_item),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_rec     (q_rec)
    );

    // Back: advance the cluster window one column per cycle while the result queue has room,
    // close clusters on a far event or at the read's end, and queue the results for the consumer
    aecl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_rec     (q_rec),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

// ===== design/aecl_front.sv =====
module aecl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                col_valid,
    output logic                col_ready,
    input  aecl_pkg::col_item_t col_item,
    output logic                q_valid,
    input  logic                q_ready,
    output aecl_pkg::col_rec_t  q_rec
);
    import aecl_pkg::*;

    logic [15:0]          col_index_reg, col_index_next;
    logic [31:0]          ref_pos_reg, ref_pos_next;
    col_rec_t             mem_reg [QUE_DEPTH];
    logic [QUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUE_CNT_W-1:0] cnt_reg, cnt_next;
    col_rec_t             rec;
    logic [31:0]          base_pos;
    logic                 push, pop;

    assign col_ready = (cnt_reg != QUE_CNT_W'(QUE_DEPTH));
    assign q_valid   = (cnt_reg != '0);
    assign q_rec     = mem_reg[rd_ptr_reg];
    assign push      = col_valid && col_ready;
    assign pop       = q_valid && q_ready;

    // Classify the column and advance the column and reference counters
    always_comb
    begin
        rec            = '0;
        col_index_next = col_index_reg;
        rec.first      = col_item.first;
        rec.last_col   = col_item.last_col;
        rec.active     = 1'b1;
        if (col_item.first)
        begin
            col_index_next = 16'd1;
        end
        else if (col_index_reg >= COL_LIMIT)
        begin
            rec.active = 1'b0;
        end
        else
        begin
            col_index_next = col_index_reg + 16'd1;
        end
        base_pos      = col_item.first ? col_item.start_pos : ref_pos_reg;
        rec.refc      = (col_item.op inside {OP_M, OP_D, OP_EQ, OP_X});
        rec.readc     = (col_item.op != OP_D);
        rec.event_hit = ((col_item.op == OP_M) && (col_item.read_base != col_item.ref_base))
                        || (col_item.op == OP_I) || (col_item.op == OP_D);
        if (col_item.op == OP_D)
            rec.cq = CH_STAR;
        else if (col_item.qual == CH_SPACE)
            rec.cq = 8'd0;
        else
            rec.cq = col_item.qual;
        rec.col      = col_index_next;
        rec.pos      = base_pos;
        ref_pos_next = (rec.active && rec.refc) ? base_pos + 32'd1 : base_pos;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QUE_CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_index_reg <= '0;
            ref_pos_reg   <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (push)
            begin
                col_index_reg <= col_index_next;
                ref_pos_reg   <= ref_pos_next;
                wr_ptr_reg    <= wr_ptr_reg + QUE_PTR_W'(1);
            end
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUE_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= rec;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QUE_CNT_W'(QUE_DEPTH))
        else $error("column queue count overflow");

    a_col_limit: assert property (@(posedge clk) disable iff (!rst_n)
        col_index_reg <= COL_LIMIT)
        else $error("column index beyond limit");

    a_first_restart: assert property (@(posedge clk) disable iff (!rst_n)
        push && col_item.first |=> col_index_reg == 16'd1)
        else $error("first column did not restart the column count");

endmodule

// ===== design/aecl_back.sv =====
module aecl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  aecl_pkg::cfg_t      cfg,
    input  logic                q_valid,
    output logic                q_ready,
    input  aecl_pkg::col_rec_t  q_rec,
    output logic                res_valid,
    input  logic                res_ready,
    output aecl_pkg::res_item_t res_item
);
    import aecl_pkg::*;

    typedef struct packed {
        logic        open;
        logic [15:0] col_lo;
        logic [15:0] col_hi;
        logic [23:0] qual;
        logic [15:0] ref_cnt;
        logic [15:0] read_cnt;
        logic [31:0] ref_lo;
        logic [31:0] ref_hi;
    } win_t;

    typedef struct packed {
        logic [23:0] qual;
        logic [15:0] ref_cnt;
        logic [15:0] read_cnt;
        logic [31:0] ref_lo;
        logic [31:0] ref_hi;
    } pend_t;

    localparam win_t WIN_CLEAR = '{open: 1'b0, col_lo: 16'd0, col_hi: 16'd0, qual: 24'd0,
                                   ref_cnt: 16'd0, read_cnt: 16'd0,
                                   ref_lo: POS_NONE, ref_hi: POS_NONE};
    localparam pend_t PEND_CLEAR = '{qual: 24'd0, ref_cnt: 16'd0, read_cnt: 16'd0,
                                     ref_lo: POS_NONE, ref_hi: POS_NONE};

    function automatic logic [23:0] sat24(input logic [25:0] v);
        return (v > 26'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
    endfunction

    function automatic logic [15:0] sat16(input logic [17:0] v);
        return (v > 18'h0_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] span_of(input win_t w);
        return w.col_hi - w.col_lo + 16'd1;
    endfunction

    function automatic res_item_t close_res(input win_t w);
        res_item_t r;
        r.col_start  = w.col_lo;
        r.col_end    = w.col_hi;
        r.ref_min    = w.ref_lo;
        r.ref_max    = w.ref_hi;
        r.qual_sum   = w.qual;
        r.span_len   = span_of(w);
        r.ref_bases  = w.ref_cnt;
        r.read_bases = w.read_cnt;
        r.last       = 1'b0;
        return r;
    endfunction

    win_t                 win_reg, win_next, b_win, p_win;
    pend_t                pend_reg, pend_next, b_pend, p_pend;
    res_item_t            rmem_reg [QUE_DEPTH];
    res_item_t            res_a, res_b, slot0, slot1;
    logic                 res_a_v, res_b_v;
    logic [QUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUE_CNT_W-1:0] rcnt_reg, rcnt_next;
    logic                 take, pop, far;
    logic [15:0]          gap;
    logic [31:0]          lo_wp, hi_acc, pos_m;

    assign q_ready   = (rcnt_reg <= QUE_CNT_W'(QUE_DEPTH - 2));
    assign take      = q_valid && q_ready;
    assign res_valid = (rcnt_reg != '0);
    assign res_item  = rmem_reg[rd_ptr_reg];
    assign pop       = res_valid && res_ready;

    always_comb
    begin
        b_win   = q_rec.first ? WIN_CLEAR : win_reg;
        b_pend  = q_rec.first ? PEND_CLEAR : pend_reg;
        p_win   = b_win;
        p_pend  = b_pend;
        res_a   = close_res(b_win);
        res_a_v = 1'b0;
        gap     = q_rec.col - b_win.col_hi;
        far     = !b_win.open || (gap > cfg.join_gap);
        pos_m   = q_rec.refc ? q_rec.pos : POS_NONE;
        lo_wp   = (b_pend.ref_lo < b_win.ref_lo) ? b_pend.ref_lo : b_win.ref_lo;
        hi_acc  = (b_win.ref_cnt != '0) ? b_win.ref_hi : 32'd0;
        if ((b_pend.ref_cnt != '0) && (b_pend.ref_hi > hi_acc))
            hi_acc = b_pend.ref_hi;
        if (q_rec.refc && (q_rec.pos > hi_acc))
            hi_acc = q_rec.pos;

        if (q_rec.active && q_rec.event_hit)
        begin
            if (far)
            begin
                // Close the old cluster, open a new one on this event
                res_a_v        = b_win.open && (span_of(b_win) >= cfg.min_span);
                p_win.open     = 1'b1;
                p_win.col_lo   = q_rec.col;
                p_win.col_hi   = q_rec.col;
                p_win.qual     = {16'd0, q_rec.cq};
                p_win.ref_cnt  = {15'd0, q_rec.refc};
                p_win.read_cnt = {15'd0, q_rec.readc};
                p_win.ref_lo   = pos_m;
                p_win.ref_hi   = pos_m;
            end
            else
            begin
                // Fold the pending gap columns and this event into the window
                p_win.col_hi   = q_rec.col;
                p_win.qual     = sat24({2'd0, b_win.qual} + {2'd0, b_pend.qual}
                                       + {18'd0, q_rec.cq});
                p_win.read_cnt = sat16({2'd0, b_win.read_cnt} + {2'd0, b_pend.read_cnt}
                                       + {17'd0, q_rec.readc});
                p_win.ref_cnt  = sat16({2'd0, b_win.ref_cnt} + {2'd0, b_pend.ref_cnt}
                                       + {17'd0, q_rec.refc});
                p_win.ref_lo   = (pos_m < lo_wp) ? pos_m : lo_wp;
                p_win.ref_hi   = ((b_win.ref_cnt != '0) || (b_pend.ref_cnt != '0)
                                  || q_rec.refc) ? hi_acc : POS_NONE;
            end
            p_pend = PEND_CLEAR;
        end
        else if (q_rec.active && b_win.open)
        begin
            p_pend.qual     = sat24({2'd0, b_pend.qual} + {18'd0, q_rec.cq});
            p_pend.read_cnt = sat16({2'd0, b_pend.read_cnt} + {17'd0, q_rec.readc});
            if (q_rec.refc)
            begin
                p_pend.ref_cnt = sat16({2'd0, b_pend.ref_cnt} + 18'd1);
                p_pend.ref_lo  = (q_rec.pos < b_pend.ref_lo) ? q_rec.pos : b_pend.ref_lo;
                p_pend.ref_hi  = ((b_pend.ref_cnt == '0) || (q_rec.pos > b_pend.ref_hi))
                                 ? q_rec.pos : b_pend.ref_hi;
            end
        end

        res_b      = close_res(p_win);
        res_b_v    = q_rec.last_col && p_win.open && (span_of(p_win) >= cfg.min_span);
        res_a.last = !res_b_v;
        res_b.last = 1'b1;

        win_next  = win_reg;
        pend_next = pend_reg;
        if (take)
        begin
            win_next  = q_rec.last_col ? WIN_CLEAR : p_win;
            pend_next = q_rec.last_col ? PEND_CLEAR : p_pend;
        end

        slot0     = res_a_v ? res_a : res_b;
        slot1     = res_b;
        rcnt_next = rcnt_reg - QUE_CNT_W'(pop);
        if (take)
            rcnt_next = rcnt_next + QUE_CNT_W'(res_a_v) + QUE_CNT_W'(res_b_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= WIN_CLEAR;
            pend_reg   <= PEND_CLEAR;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            rcnt_reg   <= '0;
        end
        else
        begin
            win_reg  <= win_next;
            pend_reg <= pend_next;
            rcnt_reg <= rcnt_next;
            if (take)
                wr_ptr_reg <= wr_ptr_reg + QUE_PTR_W'(res_a_v) + QUE_PTR_W'(res_b_v);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUE_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && (res_a_v || res_b_v))
            rmem_reg[wr_ptr_reg] <= slot0;
        if (take && res_a_v && res_b_v)
            rmem_reg[wr_ptr_reg + QUE_PTR_W'(1)] <= slot1;
    end

    a_rcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg <= QUE_CNT_W'(QUE_DEPTH))
        else $error("result queue overflow");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        take && q_rec.last_col |=> !win_reg.open)
        else $error("cluster left open after last column");

    a_event_opens: assert property (@(posedge clk) disable iff (!rst_n)
        take && q_rec.active && q_rec.event_hit && !q_rec.last_col
        |=> win_reg.open && (win_reg.col_hi == $past(q_rec.col)))
        else $error("event column not recorded as cluster end");

    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        win_reg.open |-> (win_reg.col_lo <= win_reg.col_hi) && (win_reg.col_lo != 16'd0))
        else $error("open cluster has an inverted span");

endmodule

// ===== bench/tb_alignment_event_clusterer_unit.sv =====
module tb_alignment_event_clusterer_unit;

    import aecl_pkg::*;

    // Op codes the block treats like S; the package gives them no name
    localparam logic [2:0] OP_RSV6 = 3'd6;
    localparam logic [2:0] OP_RSV7 = 3'd7;

    localparam logic [7:0] NUCLEOTIDES [4] = '{"A", "C", "G", "T"};

    // Worst quiet stretch of a correct run is the receiver hold-off plus a few
    // idle draws; the limit sits well above it
    localparam int          QUIET_LIMIT       = 2000;
    localparam int          HOLD_OFF_CYCLES   = 150;
    localparam int          SETTLE_CYCLES     = 4;
    localparam int          PHASE_COUNT       = 8;
    localparam int          HOLD_PHASE        = 0;
    localparam int unsigned COLUMNS_PER_PHASE = 148;

    // Register settings of the random phases: both extremes of the join gap and
    // the low extreme of the minimum span
    localparam logic [15:0] PHASE_GAP [PHASE_COUNT] =
        '{16'd0, 16'd1, 16'd2, 16'd5, 16'd8, 16'd3, 16'hFFFF, 16'd16};
    localparam logic [15:0] PHASE_SPAN [PHASE_COUNT] =
        '{16'd1, 16'd1, 16'd3, 16'd2, 16'd1, 16'd5, 16'd1, 16'd12};

    typedef struct {
        col_item_t column;
        bit        typed;
        res_item_t want;
    } script_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      col_valid;
    logic      col_ready;
    col_item_t col_item;
    logic      res_valid;
    logic      res_ready;
    res_item_t res_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    // Expected cluster reports, oldest first
    res_item_t   reports_due[$];
    script_row_t script[$];

    int unsigned mismatches      = 0;
    int unsigned reports_checked = 0;
    int unsigned columns_sent    = 0;
    int unsigned reads_sent      = 0;
    int unsigned settings_used   = 0;
    int          quiet_cycles    = 0;

    // Idling controls: each side toggles between idling and streaming now and then
    bit          feed_idling     = 1'b1;
    int unsigned feed_gap_max    = 17;
    bit          sink_idling     = 1'b1;
    bit          hold_off_request = 1'b0;

    // Predictor copy of the registers and the clustering state
    int unsigned gap_limit;
    int unsigned span_floor;
    int unsigned col_no;
    logic [31:0] ref_pos;
    bit          win_open;
    int unsigned win_first, win_last;
    int unsigned win_q, hold_q;
    int unsigned win_refs, hold_refs;
    int unsigned win_reads, hold_reads;
    logic [31:0] win_lo, win_hi, hold_lo, hold_hi;

    alignment_event_clusterer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .col_valid (col_valid),
        .col_ready (col_ready),
        .col_item  (col_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int unsigned sat_add(int unsigned a, int unsigned b, int unsigned cap);
        longint unsigned s;
        s = {32'd0, a} + {32'd0, b};
        return (s > cap) ? cap : s[31:0];
    endfunction

    // Fold a block of reference positions into a running low/high/count
    function automatic void merge_span(ref logic [31:0] lo, ref logic [31:0] hi,
                                       ref int unsigned cnt, input logic [31:0] blo,
                                       input logic [31:0] bhi, input int unsigned bcnt);
        if (bcnt == 0)
            return;
        if (cnt == 0)
        begin
            lo = blo;
            hi = bhi;
        end
        else
        begin
            if (blo < lo) lo = blo;
            if (bhi > hi) hi = bhi;
        end
        cnt = sat_add(cnt, bcnt, 32'hFFFF);
    endfunction

    function automatic void clear_pending();
        hold_q     = 0;
        hold_refs  = 0;
        hold_reads = 0;
        hold_lo    = POS_NONE;
        hold_hi    = POS_NONE;
    endfunction

    function automatic void clear_window();
        win_open  = 1'b0;
        win_first = 0;
        win_last  = 0;
        win_q     = 0;
        win_refs  = 0;
        win_reads = 0;
        win_lo    = POS_NONE;
        win_hi    = POS_NONE;
        clear_pending();
    endfunction

    // Close the open cluster, reporting it if it is wide enough
    function automatic void close_window(ref res_item_t made[$]);
        res_item_t   r;
        int unsigned span;
        if (win_open)
        begin
            span = win_last - win_first + 1;
            if (span >= span_floor)
            begin
                r.col_start  = 16'(win_first);
                r.col_end    = 16'(win_last);
                r.ref_min    = (win_refs != 0) ? win_lo : POS_NONE;
                r.ref_max    = (win_refs != 0) ? win_hi : POS_NONE;
                r.qual_sum   = 24'(win_q);
                r.span_len   = (span > 16'hFFFF) ? 16'hFFFF : 16'(span);
                r.ref_bases  = 16'(win_refs);
                r.read_bases = 16'(win_reads);
                r.last       = 1'b0;
                made.insert(made.size(), r);
            end
        end
        clear_window();
    endfunction

    function automatic void reset_predictor();
        gap_limit  = 32'(JOIN_GAP_RST);
        span_floor = 32'(MIN_SPAN_RST);
        col_no     = 0;
        ref_pos    = '0;
        clear_window();
    endfunction

    // Advance the clustering by one column and collect the reports it closes
    function automatic void predict_reports(input col_item_t c, ref res_item_t made[$]);
        bit          active;
        bit          refc;
        bit          readc;
        bit          hit;
        int unsigned cq;
        logic [31:0] pos;
        active = 1'b1;
        if (c.first)
        begin
            clear_window();
            col_no  = 1;
            ref_pos = c.start_pos;
        end
        else if (col_no >= MAX_COLUMNS)
            active = 1'b0;
        else
            col_no++;

        if (active)
        begin
            refc  = (c.op == OP_M) || (c.op == OP_D) || (c.op == OP_EQ) || (c.op == OP_X);
            readc = (c.op != OP_D);
            hit   = ((c.op == OP_M) && (c.read_base != c.ref_base)) ||
                    (c.op == OP_I) || (c.op == OP_D);
            cq    = (c.op == OP_D) ? 32'(CH_STAR)
                                   : ((c.qual == CH_SPACE) ? 32'd0 : 32'(c.qual));
            pos   = ref_pos;
            if (hit)
            begin
                if (!win_open || (col_no - win_last > gap_limit))
                begin
                    close_window(made);
                    win_open  = 1'b1;
                    win_first = col_no;
                end
                else
                begin
                    // gap columns since the previous event now belong to the span
                    win_q     = sat_add(win_q, hold_q, 32'hFF_FFFF);
                    win_reads = sat_add(win_reads, hold_reads, 32'hFFFF);
                    merge_span(win_lo, win_hi, win_refs, hold_lo, hold_hi, hold_refs);
                    clear_pending();
                end
                win_last = col_no;
                win_q    = sat_add(win_q, cq, 32'hFF_FFFF);
                if (readc)
                    win_reads = sat_add(win_reads, 1, 32'hFFFF);
                if (refc)
                    merge_span(win_lo, win_hi, win_refs, pos, pos, 1);
            end
            else if (win_open)
            begin
                hold_q = sat_add(hold_q, cq, 32'hFF_FFFF);
                if (readc)
                    hold_reads = sat_add(hold_reads, 1, 32'hFFFF);
                if (refc)
                    merge_span(hold_lo, hold_hi, hold_refs, pos, pos, 1);
            end
            if (refc)
                ref_pos = ref_pos + 32'd1;
        end

        if (c.last_col)
            close_window(made);
        if (made.size() != 0)
            made[made.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one column request; valid is held across back-to-back requests and
    // only dropped when an idle gap is drawn
    task automatic send_column(input col_item_t c, input bit typed = 1'b0,
                               input res_item_t want = '0);
        int unsigned pause;
        res_item_t   made[$];
        pause = feed_idling ? $urandom_range(0, feed_gap_max) : 0;
        if ($urandom_range(0, 39) == 0)
            feed_idling = !feed_idling;
        if (pause != 0)
        begin
            col_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        col_valid <= 1'b1;
        col_item  <= c;
        @(posedge clk);
        while (!col_ready)
            @(posedge clk);
        predict_reports(c, made);
        // pinned rows carry their report typed in; the predictor still advances
        if (typed)
            reports_due.insert(reports_due.size(), want);
        else
            foreach (made[i])
                reports_due.insert(reports_due.size(), made[i]);
        columns_sent++;
    endtask

    // Write both registers in one burst, holding valid between the two requests
    task automatic program_regs(input logic [15:0] join_gap, input logic [15:0] min_span);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_JOIN_GAP;
        cfg_data  <= join_gap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        gap_limit = 32'(join_gap);
        cfg_index <= CFG_MIN_SPAN;
        cfg_data  <= min_span;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        span_floor = 32'(min_span);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Drop valid, wait for every report due, then idle with valid low to let the
    // pipeline settle
    task automatic drain_reports();
        col_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] any_base();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return NUCLEOTIDES[$urandom_range(0, 3)];
    endfunction

    function automatic col_item_t random_column(int unsigned event_pct);
        col_item_t   c;
        int unsigned roll;
        c = '0;
        c.read_base = any_base();
        c.ref_base  = any_base();
        if ($urandom_range(0, 99) < event_pct)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    c.op = OP_M;
                    if (c.ref_base == c.read_base)
                        c.ref_base = c.ref_base ^ 8'h01;
                end
                1:
                begin
                    c.op       = OP_I;
                    c.ref_base = CH_STAR;
                end
                default:
                begin
                    c.op        = OP_D;
                    c.read_base = CH_STAR;
                end
            endcase
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    c.op       = OP_M;
                    c.ref_base = c.read_base;
                end
                3, 4:    c.op = OP_EQ;
                5:       c.op = OP_X;
                6, 7:
                begin
                    c.op       = OP_S;
                    c.ref_base = CH_STAR;
                end
                8:       c.op = OP_RSV6;
                default: c.op = OP_RSV7;
            endcase
        end
        roll = $urandom_range(0, 9);
        if (roll == 0)
            c.qual = CH_SPACE;
        else if (roll == 1)
            c.qual = 8'($urandom_range(0, 255));
        else
            c.qual = 8'($urandom_range(33, 74));
        return c;
    endfunction

    // One read of random content; now and then a start or end marker is
    // dropped or misplaced so that broken reads reach the block too
    task automatic send_random_read();
        int unsigned cols;
        int unsigned event_pct;
        logic [31:0] start;
        col_item_t   c;
        cols = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 90) : $urandom_range(1, 30);
        case ($urandom_range(0, 2))
            0:       event_pct = 5;
            1:       event_pct = 25;
            default: event_pct = 60;
        endcase
        start = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40) : $urandom;
        for (int unsigned k = 0; k < cols; k++)
        begin
            c           = random_column(event_pct);
            c.start_pos = (k == 0) ? start : $urandom;
            c.first     = (k == 0);
            c.last_col  = (k == cols - 1);
            if ($urandom_range(0, 59) == 0)
                c.first = !c.first;
            if ($urandom_range(0, 59) == 0)
                c.last_col = !c.last_col;
            send_column(c);
        end
        reads_sent++;
    endtask

    // ------------------------------------------------------------------
    // Directed script
    // ------------------------------------------------------------------

    function automatic void add_row(logic [2:0] op, logic [7:0] rb, logic [7:0] fb,
                                    logic [7:0] q, logic [31:0] sp, bit f, bit l);
        script_row_t r;
        r.column.op        = op;
        r.column.read_base = rb;
        r.column.ref_base  = fb;
        r.column.qual      = q;
        r.column.start_pos = sp;
        r.column.first     = f;
        r.column.last_col  = l;
        r.typed            = 1'b0;
        r.want             = '0;
        script.insert(script.size(), r);
    endfunction

    // Pin the single report of the row just added
    function automatic void pin_report(logic [15:0] cs, logic [15:0] ce, logic [31:0] lo,
                                       logic [31:0] hi, logic [23:0] q, logic [15:0] span,
                                       logic [15:0] refs, logic [15:0] reads);
        res_item_t r;
        r.col_start  = cs;
        r.col_end    = ce;
        r.ref_min    = lo;
        r.ref_max    = hi;
        r.qual_sum   = q;
        r.span_len   = span;
        r.ref_bases  = refs;
        r.read_bases = reads;
        r.last       = 1'b1;
        script[script.size() - 1].typed = 1'b1;
        script[script.size() - 1].want  = r;
    endfunction

    // ------------------------------------------------------------------
    // Result sink: per-report idle draws, plus one long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin : sink
        int unsigned pause;
        res_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_request)
            begin
                // starve the output so the block fills up and stalls its input
                res_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_request = 1'b0;
            end
            pause = sink_idling ? $urandom_range(0, 17) : 0;
            if ($urandom_range(0, 39) == 0)
                sink_idling = !sink_idling;
            if (pause != 0)
            begin
                res_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Report checker and progress counter
    // ------------------------------------------------------------------

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: report field %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : report_check
        res_item_t want;
        if (rst_n !== 1'b1)
            quiet_cycles = 0;
        else
        begin
            if ((col_valid && col_ready) || (res_valid && res_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (res_valid && res_ready)
            begin
                if (reports_due.size() == 0)
                begin
                    $display("%0t: report with none due, expected nothing, got %p",
                             $time, res_item);
                    mismatches++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    compare_field("col_start", 32'(want.col_start), 32'(res_item.col_start));
                    compare_field("col_end", 32'(want.col_end), 32'(res_item.col_end));
                    compare_field("ref_min", want.ref_min, res_item.ref_min);
                    compare_field("ref_max", want.ref_max, res_item.ref_max);
                    compare_field("qual_sum", 32'(want.qual_sum), 32'(res_item.qual_sum));
                    compare_field("span_len", 32'(want.span_len), 32'(res_item.span_len));
                    compare_field("ref_bases", 32'(want.ref_bases), 32'(res_item.ref_bases));
                    compare_field("read_bases", 32'(want.read_bases),
                                  32'(res_item.read_bases));
                    compare_field("last", 32'(want.last), 32'(res_item.last));
                    reports_checked++;
                end
            end
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no request moved for %0d cycles, %0d reports still due",
                 $time, QUIET_LIMIT, reports_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int unsigned phase_start;

        col_valid <= 1'b0;
        col_item  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_JOIN_GAP;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        reset_predictor();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset settings (join gap 5, minimum span 2).
        // Columns before any first: counted from column 1 at position 0.
        add_row(OP_M, "A", "T", 8'd48, 32'd0, 1'b0, 1'b0);
        add_row(OP_D, CH_STAR, "G", 8'hFF, 32'd0, 1'b0, 1'b1);
        pin_report(16'd1, 16'd2, 32'd0, 32'd1, 24'd90, 16'd2, 16'd2, 16'd1);

        // Gap columns of both undefined ops inside a span, a D column whose qual
        // byte is ignored, and a space quality byte that adds nothing
        add_row(OP_M, "A", "A", 8'd73, 32'd100, 1'b1, 1'b0);
        add_row(OP_M, "C", "A", 8'd40, 32'd0, 1'b0, 1'b0);
        add_row(OP_RSV6, "G", CH_STAR, 8'd50, 32'd0, 1'b0, 1'b0);
        add_row(OP_RSV7, "T", CH_STAR, 8'd10, 32'd0, 1'b0, 1'b0);
        add_row(OP_D, CH_STAR, "G", 8'd0, 32'd0, 1'b0, 1'b0);
        add_row(OP_I, "T", CH_STAR, CH_SPACE, 32'd0, 1'b0, 1'b1);
        pin_report(16'd2, 16'd6, 32'd101, 32'd102, 24'd142, 16'd5, 16'd2, 16'd4);

        // Cluster with no reference column; field extremes
        add_row(OP_I, 8'hFF, 8'h00, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_row(OP_I, 8'h00, 8'hFF, 8'h00, 32'h0000_0000, 1'b0, 1'b1);
        pin_report(16'd1, 16'd2, POS_NONE, POS_NONE, 24'd255, 16'd2, 16'd0, 16'd2);

        // Positions wrapping through zero, equal and X columns, then an event one
        // column beyond the join gap that closes the cluster on the last column
        add_row(OP_M, "A", "C", 8'd73, 32'hFFFF_FFFE, 1'b1, 1'b0);
        add_row(OP_EQ, "A", "A", 8'd60, 32'd0, 1'b0, 1'b0);
        add_row(OP_X, "G", "T", 8'd61, 32'd0, 1'b0, 1'b0);
        add_row(OP_D, CH_STAR, "A", 8'd70, 32'd0, 1'b0, 1'b0);
        repeat (5) add_row(OP_S, "A", CH_STAR, 8'd35, 32'd0, 1'b0, 1'b0);
        add_row(OP_I, "C", CH_STAR, 8'd50, 32'd0, 1'b0, 1'b1);
        pin_report(16'd1, 16'd4, 32'd0, 32'hFFFF_FFFF, 24'd236, 16'd4, 16'd4, 16'd3);

        // A new first while a cluster is open drops it unreported
        add_row(OP_I, "A", CH_STAR, 8'd40, 32'd500, 1'b1, 1'b0);
        add_row(OP_I, "G", CH_STAR, 8'd40, 32'd0, 1'b0, 1'b0);
        add_row(OP_EQ, "A", "A", 8'd40, 32'd600, 1'b1, 1'b0);
        add_row(OP_M, "A", "A", 8'd40, 32'd0, 1'b0, 1'b1);

        foreach (script[i])
            send_column(script[i].column, script[i].typed, script[i].want);

        // Random reads under a series of settings; hold the output off once
        // while the dense, every-event-reports setting is running
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain_reports();
            program_regs(PHASE_GAP[p], PHASE_SPAN[p]);
            if (p == HOLD_PHASE)
                hold_off_request = 1'b1;
            phase_start = columns_sent;
            while (columns_sent - phase_start < COLUMNS_PER_PHASE)
                send_random_read();
        end
        drain_reports();

        $display("Run covered %0d column requests in %0d reads under %0d register settings,",
                 columns_sent, reads_sent, settings_used);
        $display("with one long output hold-off; %0d cluster reports compared.",
                 reports_checked);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
